// ----- sv/lcdnw_pkg.sv -----
`timescale 1ns / 1ps

package lcdnw_pkg;

    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 8;
    localparam int NIBBLE_W = 4;
    localparam int HOLD_W   = 11;
    localparam int PC_W     = 4;
    localparam int PHASE_W  = 2;

    localparam logic [REQ_W-1:0] REQ_CMD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POS  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_INIT = 2'd3;

    localparam logic [HOLD_W-1:0] HOLD_SHORT = 11'd1;
    localparam logic [HOLD_W-1:0] HOLD_BYTE  = 11'd50;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR = 11'd1600;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] PC_CMD   = 4'd0;
    localparam logic [PC_W-1:0] PC_DATA  = 4'd1;
    localparam logic [PC_W-1:0] PC_POS   = 4'd2;
    localparam logic [PC_W-1:0] PC_INIT  = 4'd3;
    localparam logic [PC_W-1:0] PC_LAST  = 4'd9;

    typedef enum logic [1:0] {
        SRC_VALUE,
        SRC_POS,
        SRC_CONST
    } src_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END,
        SEQ_END_IF_ZERO
    } seq_t;

    typedef struct packed {
        src_t               src;
        logic               rs;
        logic [VALUE_W-1:0] const_byte;
        seq_t               seq;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h00, seq: SEQ_END};
        case (pc)
            PC_CMD:  w = '{src: SRC_VALUE, rs: 1'b0, const_byte: 8'h00, seq: SEQ_END};
            PC_DATA: w = '{src: SRC_VALUE, rs: 1'b1, const_byte: 8'h00, seq: SEQ_END};
            PC_POS:  w = '{src: SRC_POS,   rs: 1'b0, const_byte: 8'h00, seq: SEQ_END};
            PC_INIT: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h33, seq: SEQ_NEXT};
            4'd4: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h32, seq: SEQ_NEXT};
            4'd5: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h28, seq: SEQ_NEXT};
            4'd6: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h0F, seq: SEQ_NEXT};
            4'd7: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h01, seq: SEQ_NEXT};
            4'd8: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h06,
                        seq: SEQ_END_IF_ZERO};
            PC_LAST: w = '{src: SRC_POS,   rs: 1'b0, const_byte: 8'h00, seq: SEQ_END};
            default: w = '{src: SRC_CONST, rs: 1'b0, const_byte: 8'h00, seq: SEQ_END};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/char_lcd_nibble_writer.sv -----
`timescale 1ns / 1ps
// char_lcd_nibble_writer: turns LCD requests into 4-bit bus pin steps.
// Input channel (s_valid/s_ready): a request of type command byte, data
// byte, cursor position or init sequence, with its 8-bit value.
// Output channel (m_valid/m_ready): one pin step per result (register
// select, enable, nibble, hold time in us), m_last on the final step.
// A byte request gives 4 steps, init gives 24, or 28 with a position.
// A small microcode table holds one control word per byte; a 2-bit phase
// counter walks the four pin steps of that byte, one step per cycle while
// m_ready is high. An accepted request is first registered in the
// sequencer, then its first step is loaded into the output register;
// the next request is taken as soon as the last step is loaded into the
// output register.
// When the receiver stalls, the output register holds its step and the
// sequencer waits. Reset (synchronous, aresetn low) drops any request in
// flight and clears m_valid; s_ready is high after reset.
module char_lcd_nibble_writer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcdnw_pkg::REQ_W-1:0]   s_req_type,
    input  logic [lcdnw_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_reg_select,
    output logic                          m_enable,
    output logic [lcdnw_pkg::NIBBLE_W-1:0] m_nibble,
    output logic [lcdnw_pkg::HOLD_W-1:0]  m_hold_us,
    output logic                          m_last
);
    import lcdnw_pkg::*;

    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [VALUE_W-1:0]  value_reg, value_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_rs_reg, m_rs_next;
    logic                m_en_reg, m_en_next;
    logic [NIBBLE_W-1:0] m_nib_reg, m_nib_next;
    logic [HOLD_W-1:0]   m_hold_reg, m_hold_next;
    logic                m_last_reg, m_last_next;

    ctrl_t               cw;
    logic [VALUE_W-1:0]  byte_sel;
    logic                byte_end;
    logic                step_go;
    logic [PC_W-1:0]     entry_pc;

    assign s_ready = !busy_reg;
    assign cw      = ucode_rom(pc_reg);
    assign step_go = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        case (s_req_type)
            REQ_CMD:  entry_pc = PC_CMD;
            REQ_DATA: entry_pc = PC_DATA;
            REQ_POS:  entry_pc = PC_POS;
            REQ_INIT: entry_pc = PC_INIT;
            default:  entry_pc = PC_CMD;
        endcase
    end

    always_comb begin
        case (cw.src)
            SRC_VALUE: byte_sel = value_reg;
            SRC_POS:   byte_sel = {1'b1, value_reg[VALUE_W-2:0]};
            SRC_CONST: byte_sel = cw.const_byte;
            default:   byte_sel = cw.const_byte;
        endcase
        case (cw.seq)
            SEQ_NEXT:        byte_end = 1'b0;
            SEQ_END:         byte_end = 1'b1;
            SEQ_END_IF_ZERO: byte_end = (value_reg == '0);
            default:         byte_end = 1'b1;
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        phase_next   = phase_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg;
        m_rs_next    = m_rs_reg;
        m_en_next    = m_en_reg;
        m_nib_next   = m_nib_reg;
        m_hold_next  = m_hold_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_valid && s_ready) begin
            busy_next  = 1'b1;
            pc_next    = entry_pc;
            phase_next = '0;
            value_next = s_value;
        end

        if (step_go) begin
            m_valid_next = 1'b1;
            m_rs_next    = cw.rs;
            m_en_next    = !phase_reg[0];
            m_nib_next   = phase_reg[1] ? byte_sel[NIBBLE_W-1:0]
                                        : byte_sel[VALUE_W-1:NIBBLE_W];
            case (phase_reg)
                2'd1:       m_hold_next = cw.rs ? HOLD_SHORT : HOLD_BYTE;
                PHASE_LAST: m_hold_next = cw.rs ? HOLD_BYTE : HOLD_CLEAR;
                default:    m_hold_next = HOLD_SHORT;
            endcase
            m_last_next = (phase_reg == PHASE_LAST) && byte_end;
            phase_next  = phase_reg + 2'd1;
            if (phase_reg == PHASE_LAST) begin
                if (byte_end) begin
                    busy_next = 1'b0;
                end else begin
                    pc_next = pc_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        m_rs_reg   <= m_rs_next;
        m_en_reg   <= m_en_next;
        m_nib_reg  <= m_nib_next;
        m_hold_reg <= m_hold_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = m_rs_reg;
    assign m_enable     = m_en_reg;
    assign m_nibble     = m_nib_reg;
    assign m_hold_us    = m_hold_reg;
    assign m_last       = m_last_reg;

    // last step of a request is always an enable-low step
    a_last_en_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> !m_en_reg)
        else $error("last step with enable high");

    // closing step of a request carries the byte hold for data, the clear hold for commands
    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |->
            ((m_rs_reg && m_hold_reg == HOLD_BYTE) ||
             (!m_rs_reg && m_hold_reg == HOLD_CLEAR)))
        else $error("bad hold on last step");

    // program counter stays inside the microcode
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= PC_LAST)
        else $error("microcode address out of range");

    // idle sequencer sits on the first phase of a byte
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> phase_reg == '0)
        else $error("phase not aligned while idle");

    // an accepted request always starts the sequencer
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> busy_reg && phase_reg == '0)
        else $error("request accepted without start");

endmodule
